### sv/ris_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ris_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 4'd0,
        REG_CENTER_Y = 4'd1,
        REG_CENTER_Z = 4'd2,
        REG_RADIUS   = 4'd3
    } t_cfg_reg;

    // discriminant and square root
    localparam int DISC_FULL_W = 136;
    localparam int SQ_N        = 63;
    localparam int DISC_W      = 2 * SQ_N;

    // root divider: quotient bits kept, numerator and compare widths
    localparam int RT_QB    = 33;
    localparam int RT_NUM_W = 68 + FRAC_BITS;
    localparam int RT_CMP_W = (RT_NUM_W > 64 + RT_QB) ? RT_NUM_W : 64 + RT_QB;

    // normal divider
    localparam int NM_QB    = 32;
    localparam int NM_NUM_W = 33 + FRAC_BITS;
    localparam int NM_CMP_W = (NM_NUM_W > 31 + NM_QB) ? NM_NUM_W : 31 + NM_QB;

    typedef logic [2:0][31:0] t_vec3;

    // side data carried along the square root stages
    typedef struct packed {
        logic               kill;
        logic [63:0]        a;
        logic signed [66:0] hb;
        t_vec3              o;
        t_vec3              d;
        logic [31:0]        lo;
        logic [31:0]        hi;
    } t_sq_side;

    // side data carried along the root divider stages
    typedef struct packed {
        logic             kill;
        logic [63:0]      a;
        t_vec3            o;
        t_vec3            d;
        logic [31:0]      lo;
        logic [31:0]      hi;
        logic             neg_n;
        logic             neg_f;
        logic             ovf_n;
        logic             ovf_f;
        logic [RT_QB-1:0] low_n;
        logic [RT_QB-1:0] low_f;
    } t_dv_side;

    // side data carried along the normal divider stages
    typedef struct packed {
        logic        hit;
        logic [31:0] t;
        t_vec3       p;
        t_vec3       d;
        logic [2:0]  neg;
        logic [2:0]  ovf;
        t_vec3       low;
    } t_nd_side;

    function automatic logic [31:0] sat_s32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/ris_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ris_ray_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               range_min, range_max,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               range_min, range_max,
        output ready
    );
endinterface

interface ris_hit_if;
    logic               valid;
    logic               ready;
    logic               hit_found;
    logic signed [31:0] hit_t;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               front_face;

    modport source (
        output valid, hit_found, hit_t, point_x, point_y, point_z,
               normal_x, normal_y, normal_z, front_face,
        input  ready
    );
    modport sink (
        input  valid, hit_found, hit_t, point_x, point_y, point_z,
               normal_x, normal_y, normal_z, front_face,
        output ready
    );
endinterface

interface ris_cfg_if import ris_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/ray_sphere_intersect_top.sv
// Ray against sphere test in signed Q16.16. One ray transfer can be taken on
// every clock cycle unless the output stalls; each ray gives exactly one
// result, in order. The pipeline holds the 63-step square root unit, the
// 33-step root dividers (near and far run side by side) and the 32-step
// normal dividers, each one bit per pipeline stage, plus 18 stages of
// products, sums, selection and saturation. The whole pipeline advances
// together: when a result sits at the output and is not taken, the input
// stops taking rays until it moves, and nothing is lost or repeated. The
// sphere center and radius are written through the configuration channel,
// which always accepts; write them only while no ray is in flight.
// Index 0..2 are center x, y, z and index 3 the radius; other indexes are
// dropped. A zero direction, zero radius, negative discriminant or a ray
// with no root in [range_min, range_max] gives an all-zero no-hit result.
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersect_top
    import ris_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ris_cfg_if.sink   i_cfg,
    ris_ray_if.sink   i_ray,
    ris_hit_if.source o_hit
);

    localparam int NSTG = 6 + SQ_N + 3 + RT_QB + 2 + 4 + NM_QB + 2 + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad;
    logic signed [31:0] cen [3];

    assign i_cfg.ready = 1'b1;
    assign cen[0] = r_cx;
    assign cen[1] = r_cy;
    assign cen[2] = r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= 31'(1) << FRAC_BITS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_CENTER_X: r_cx  <= i_cfg.data;
                REG_CENTER_Y: r_cy  <= i_cfg.data;
                REG_CENTER_Z: r_cz  <= i_cfg.data;
                REG_RADIUS:   r_rad <= i_cfg.data[30:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: all stages move together unless the output holds
    // a result that has not been taken
    // ------------------------------------------------------------------
    logic            adv;
    logic [NSTG-1:0] r_vld;

    assign adv         = !r_vld[NSTG-1] || o_hit.ready;
    assign i_ray.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_ray.valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: offset from center, degenerate ray or sphere
    // ------------------------------------------------------------------
    t_vec3              r1_o, r1_d;
    logic [31:0]        r1_lo, r1_hi;
    logic signed [32:0] r1_oc [3];
    logic               r1_kill;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_o    <= {i_ray.origin_z, i_ray.origin_y, i_ray.origin_x};
            r1_d    <= {i_ray.dir_z, i_ray.dir_y, i_ray.dir_x};
            r1_lo   <= i_ray.range_min;
            r1_hi   <= i_ray.range_max;
            r1_oc[0] <= 33'(i_ray.origin_x) - 33'(r_cx);
            r1_oc[1] <= 33'(i_ray.origin_y) - 33'(r_cy);
            r1_oc[2] <= 33'(i_ray.origin_z) - 33'(r_cz);
            r1_kill <= (i_ray.dir_x == '0 && i_ray.dir_y == '0 && i_ray.dir_z == '0)
                       || (r_rad == '0);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: per-axis products for a, half b and c
    // ------------------------------------------------------------------
    t_vec3              r2_o, r2_d;
    logic [31:0]        r2_lo, r2_hi;
    logic               r2_kill;
    logic signed [63:0] r2_dd [3];
    logic signed [64:0] r2_od [3];
    logic signed [65:0] r2_oo [3];
    logic [61:0]        r2_rr;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_dd[i] <= $signed(r1_d[i]) * $signed(r1_d[i]);
                r2_od[i] <= r1_oc[i] * $signed(r1_d[i]);
                r2_oo[i] <= r1_oc[i] * r1_oc[i];
            end
            r2_rr   <= r_rad * r_rad;
            r2_o    <= r1_o;
            r2_d    <= r1_d;
            r2_lo   <= r1_lo;
            r2_hi   <= r1_hi;
            r2_kill <= r1_kill;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: a = d.d, hb = oc.d, c = oc.oc - r*r
    // ------------------------------------------------------------------
    t_vec3              r3_o, r3_d;
    logic [31:0]        r3_lo, r3_hi;
    logic               r3_kill;
    logic [63:0]        r3_a;
    logic signed [66:0] r3_hb;
    logic signed [67:0] r3_c;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_a  <= 64'(r2_dd[0]) + 64'(r2_dd[1]) + 64'(r2_dd[2]);
            r3_hb <= 67'(r2_od[0]) + 67'(r2_od[1]) + 67'(r2_od[2]);
            r3_c  <= 68'(r2_oo[0]) + 68'(r2_oo[1]) + 68'(r2_oo[2]) - 68'(r2_rr);
            r3_o    <= r2_o;
            r3_d    <= r2_d;
            r3_lo   <= r2_lo;
            r3_hi   <= r2_hi;
            r3_kill <= r2_kill;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: partial products of hb*hb and a*c on split halves
    // ------------------------------------------------------------------
    t_vec3              r4_o, r4_d;
    logic [31:0]        r4_lo, r4_hi;
    logic               r4_kill;
    logic [63:0]        r4_a;
    logic signed [66:0] r4_hb;
    logic signed [65:0] r4_hhh;
    logic signed [67:0] r4_hhl;
    logic [67:0]        r4_hll;
    logic signed [66:0] r4_ahch, r4_alch;
    logic [65:0]        r4_ahcl, r4_alcl;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_hhh  <= $signed(r3_hb[66:34]) * $signed(r3_hb[66:34]);
            r4_hhl  <= $signed(r3_hb[66:34]) * $signed({1'b0, r3_hb[33:0]});
            r4_hll  <= r3_hb[33:0] * r3_hb[33:0];
            r4_ahch <= $signed({1'b0, r3_a[63:32]}) * $signed(r3_c[67:34]);
            r4_alch <= $signed({1'b0, r3_a[31:0]}) * $signed(r3_c[67:34]);
            r4_ahcl <= r3_a[63:32] * r3_c[33:0];
            r4_alcl <= r3_a[31:0] * r3_c[33:0];
            r4_a    <= r3_a;
            r4_hb   <= r3_hb;
            r4_o    <= r3_o;
            r4_d    <= r3_d;
            r4_lo   <= r3_lo;
            r4_hi   <= r3_hi;
            r4_kill <= r3_kill;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: recombine hb*hb and a*c
    // ------------------------------------------------------------------
    t_vec3                  r5_o, r5_d;
    logic [31:0]            r5_lo, r5_hi;
    logic                   r5_kill;
    logic [63:0]            r5_a;
    logic signed [66:0]     r5_hb;
    logic [DISC_FULL_W-1:0] r5_hb2, r5_ac;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_hb2 <= (DISC_FULL_W'(r4_hhh) << 68) + (DISC_FULL_W'(r4_hhl) << 35)
                      + DISC_FULL_W'(r4_hll);
            r5_ac  <= (DISC_FULL_W'(r4_ahch) << 66) + (DISC_FULL_W'(r4_ahcl) << 32)
                      + (DISC_FULL_W'(r4_alch) << 34) + DISC_FULL_W'(r4_alcl);
            r5_a    <= r4_a;
            r5_hb   <= r4_hb;
            r5_o    <= r4_o;
            r5_d    <= r4_d;
            r5_lo   <= r4_lo;
            r5_hi   <= r4_hi;
            r5_kill <= r4_kill;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: discriminant, loads the square root pipe
    // a nonnegative discriminant is bounded by a*r*r, below 2^126
    // ------------------------------------------------------------------
    logic [DISC_FULL_W-1:0] disc;
    logic [DISC_W-1:0]      r_sq_rem  [SQ_N+1];
    logic [SQ_N-1:0]        r_sq_q    [SQ_N+1];
    t_sq_side               r_sq_side [SQ_N+1];
    t_sq_side               n_sq0;

    assign disc = r5_hb2 - r5_ac;

    always_comb begin
        n_sq0.kill = r5_kill || disc[DISC_FULL_W-1];
        n_sq0.a    = r5_a;
        n_sq0.hb   = r5_hb;
        n_sq0.o    = r5_o;
        n_sq0.d    = r5_d;
        n_sq0.lo   = r5_lo;
        n_sq0.hi   = r5_hi;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem[0]  <= disc[DISC_W-1:0];
            r_sq_q[0]    <= '0;
            r_sq_side[0] <= n_sq0;
        end
    end

    // one root bit per stage, most significant first
    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam int B = SQ_N - 1 - k;
        logic [DISC_W-1:0] trial;

        assign trial = (DISC_W'(r_sq_q[k]) << (B + 1)) | (DISC_W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (r_sq_rem[k] >= trial) begin
                    r_sq_rem[k+1] <= r_sq_rem[k] - trial;
                    r_sq_q[k+1]   <= r_sq_q[k] | (SQ_N'(1) << B);
                end else begin
                    r_sq_rem[k+1] <= r_sq_rem[k];
                    r_sq_q[k+1]   <= r_sq_q[k];
                end
                r_sq_side[k+1] <= r_sq_side[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // root numerators: -hb - s (near) and -hb + s (far)
    // ------------------------------------------------------------------
    t_sq_side           sq_out;
    logic signed [68:0] neg_hb;
    logic signed [68:0] r7_nn, r7_nf;
    t_sq_side           r7_side;

    assign sq_out = r_sq_side[SQ_N];
    assign neg_hb = -69'(sq_out.hb);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_nn   <= neg_hb - 69'(r_sq_q[SQ_N]);
            r7_nf   <= neg_hb + 69'(r_sq_q[SQ_N]);
            r7_side <= sq_out;
        end
    end

    // magnitude and sign of each numerator
    logic [67:0] r8_mn, r8_mf;
    logic        r8_negn, r8_negf;
    t_sq_side    r8_side;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_mn   <= r7_nn[68] ? 68'(-r7_nn) : r7_nn[67:0];
            r8_mf   <= r7_nf[68] ? 68'(-r7_nf) : r7_nf[67:0];
            r8_negn <= r7_nn[68];
            r8_negf <= r7_nf[68];
            r8_side <= r7_side;
        end
    end

    // ------------------------------------------------------------------
    // load the root dividers; a quotient of 2^33 or more can never fall
    // inside a 32-bit interval, so only the low 33 bits are worked out
    // ------------------------------------------------------------------
    logic [RT_NUM_W-1:0] num_n, num_f;
    logic [RT_CMP_W-1:0] a_lim;
    t_dv_side            n_dv0;
    logic [63:0]         r_dn_rem  [RT_QB+1];
    logic [63:0]         r_df_rem  [RT_QB+1];
    logic [RT_QB-1:0]    r_dn_q    [RT_QB+1];
    logic [RT_QB-1:0]    r_df_q    [RT_QB+1];
    t_dv_side            r_dv_side [RT_QB+1];

    assign num_n = RT_NUM_W'(r8_mn) << FRAC_BITS;
    assign num_f = RT_NUM_W'(r8_mf) << FRAC_BITS;
    assign a_lim = RT_CMP_W'(r8_side.a) << RT_QB;

    always_comb begin
        n_dv0.kill  = r8_side.kill;
        n_dv0.a     = r8_side.a;
        n_dv0.o     = r8_side.o;
        n_dv0.d     = r8_side.d;
        n_dv0.lo    = r8_side.lo;
        n_dv0.hi    = r8_side.hi;
        n_dv0.neg_n = r8_negn;
        n_dv0.neg_f = r8_negf;
        n_dv0.ovf_n = RT_CMP_W'(num_n) >= a_lim;
        n_dv0.ovf_f = RT_CMP_W'(num_f) >= a_lim;
        n_dv0.low_n = num_n[RT_QB-1:0];
        n_dv0.low_f = num_f[RT_QB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dn_rem[0]  <= 64'(num_n >> RT_QB);
            r_df_rem[0]  <= 64'(num_f >> RT_QB);
            r_dn_q[0]    <= '0;
            r_df_q[0]    <= '0;
            r_dv_side[0] <= n_dv0;
        end
    end

    // restoring division, one quotient bit per stage for each root
    for (genvar k = 0; k < RT_QB; k++) begin : g_rdiv
        localparam int J = RT_QB - 1 - k;
        logic [64:0] tr_n, tr_f, den;

        assign tr_n = {r_dn_rem[k], r_dv_side[k].low_n[J]};
        assign tr_f = {r_df_rem[k], r_dv_side[k].low_f[J]};
        assign den  = {1'b0, r_dv_side[k].a};

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (tr_n >= den) begin
                    r_dn_rem[k+1] <= 64'(tr_n - den);
                    r_dn_q[k+1]   <= r_dn_q[k] | (RT_QB'(1) << J);
                end else begin
                    r_dn_rem[k+1] <= tr_n[63:0];
                    r_dn_q[k+1]   <= r_dn_q[k];
                end
                if (tr_f >= den) begin
                    r_df_rem[k+1] <= 64'(tr_f - den);
                    r_df_q[k+1]   <= r_df_q[k] | (RT_QB'(1) << J);
                end else begin
                    r_df_rem[k+1] <= tr_f[63:0];
                    r_df_q[k+1]   <= r_df_q[k];
                end
                r_dv_side[k+1] <= r_dv_side[k];
            end
        end
    end

    // signed roots, truncated toward zero
    logic signed [RT_QB:0] r9_tn, r9_tf;
    t_dv_side              r9_side;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r9_tn   <= r_dv_side[RT_QB].neg_n ? -(RT_QB+1)'(r_dn_q[RT_QB])
                                              : (RT_QB+1)'(r_dn_q[RT_QB]);
            r9_tf   <= r_dv_side[RT_QB].neg_f ? -(RT_QB+1)'(r_df_q[RT_QB])
                                              : (RT_QB+1)'(r_df_q[RT_QB]);
            r9_side <= r_dv_side[RT_QB];
        end
    end

    // ------------------------------------------------------------------
    // interval test: near root wins, far root is the fallback
    // ------------------------------------------------------------------
    logic        in_n, in_f;
    logic [31:0] r10_t;
    logic        r10_hit;
    t_vec3       r10_o, r10_d;

    assign in_n = !r9_side.ovf_n && r9_tn >= $signed(r9_side.lo)
                  && r9_tn <= $signed(r9_side.hi);
    assign in_f = !r9_side.ovf_f && r9_tf >= $signed(r9_side.lo)
                  && r9_tf <= $signed(r9_side.hi);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r10_hit <= !r9_side.kill && (in_n || in_f);
            r10_t   <= in_n ? r9_tn[31:0] : r9_tf[31:0];
            r10_o   <= r9_side.o;
            r10_d   <= r9_side.d;
        end
    end

    // ------------------------------------------------------------------
    // hit point: o + floor(t*d / 2^F), saturated
    // ------------------------------------------------------------------
    logic signed [63:0] r11_td [3];
    logic [31:0]        r11_t;
    logic               r11_hit;
    t_vec3              r11_o, r11_d;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r11_td[i] <= $signed(r10_t) * $signed(r10_d[i]);
            end
            r11_t   <= r10_t;
            r11_hit <= r10_hit;
            r11_o   <= r10_o;
            r11_d   <= r10_d;
        end
    end

    t_vec3       r12_p, r12_d;
    logic [31:0] r12_t;
    logic        r12_hit;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r12_p[i] <= sat_s32(66'($signed(r11_o[i])) + 66'(r11_td[i] >>> FRAC_BITS));
            end
            r12_t   <= r11_t;
            r12_hit <= r11_hit;
            r12_d   <= r11_d;
        end
    end

    // distance from center, as sign and magnitude
    logic signed [32:0] diff [3];
    logic [32:0]        r13_mag [3];
    logic [2:0]         r13_neg;
    t_vec3              r13_p, r13_d;
    logic [31:0]        r13_t;
    logic               r13_hit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = 33'($signed(r12_p[i])) - 33'(cen[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r13_mag[i] <= diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
                r13_neg[i] <= diff[i][32];
            end
            r13_p   <= r12_p;
            r13_d   <= r12_d;
            r13_t   <= r12_t;
            r13_hit <= r12_hit;
        end
    end

    // ------------------------------------------------------------------
    // load the normal dividers; a quotient of 2^32 or more saturates
    // ------------------------------------------------------------------
    logic [NM_NUM_W-1:0] nm_num [3];
    logic [NM_CMP_W-1:0] rad_lim;
    t_nd_side            n_nd0;
    logic [2:0][30:0]    r_nd_rem  [NM_QB+1];
    logic [2:0][31:0]    r_nd_q    [NM_QB+1];
    t_nd_side            r_nd_side [NM_QB+1];

    assign rad_lim = NM_CMP_W'(r_rad) << NM_QB;

    always_comb begin
        n_nd0.hit = r13_hit;
        n_nd0.t   = r13_t;
        n_nd0.p   = r13_p;
        n_nd0.d   = r13_d;
        n_nd0.neg = r13_neg;
        for (int i = 0; i < 3; i++) begin
            nm_num[i]    = NM_NUM_W'(r13_mag[i]) << FRAC_BITS;
            n_nd0.ovf[i] = NM_CMP_W'(nm_num[i]) >= rad_lim;
            n_nd0.low[i] = nm_num[i][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_nd_rem[0][i] <= 31'(nm_num[i] >> NM_QB);
            end
            r_nd_q[0]    <= '0;
            r_nd_side[0] <= n_nd0;
        end
    end

    for (genvar k = 0; k < NM_QB; k++) begin : g_ndiv
        localparam int J = NM_QB - 1 - k;
        logic [31:0] tr [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                tr[i] = {r_nd_rem[k][i], r_nd_side[k].low[i][J]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int i = 0; i < 3; i++) begin
                    if (tr[i] >= {1'b0, r_rad}) begin
                        r_nd_rem[k+1][i] <= 31'(tr[i] - {1'b0, r_rad});
                        r_nd_q[k+1][i]   <= r_nd_q[k][i] | (32'(1) << J);
                    end else begin
                        r_nd_rem[k+1][i] <= tr[i][30:0];
                        r_nd_q[k+1][i]   <= r_nd_q[k][i];
                    end
                end
                r_nd_side[k+1] <= r_nd_side[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // outward normal with sign and saturation
    // ------------------------------------------------------------------
    t_nd_side            nd_out;
    logic signed [32:0]  nq [3];
    t_vec3               r14_n, r14_p, r14_d;
    logic [31:0]         r14_t;
    logic                r14_hit;

    assign nd_out = r_nd_side[NM_QB];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nq[i] = nd_out.neg[i] ? -33'(r_nd_q[NM_QB][i]) : 33'(r_nd_q[NM_QB][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                if (nd_out.ovf[i]) begin
                    r14_n[i] <= nd_out.neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
                end else if (!nd_out.neg[i] && r_nd_q[NM_QB][i][31]) begin
                    r14_n[i] <= 32'h7fff_ffff;
                end else begin
                    r14_n[i] <= sat_s32(66'(nq[i]));
                end
            end
            r14_p   <= nd_out.p;
            r14_d   <= nd_out.d;
            r14_t   <= nd_out.t;
            r14_hit <= nd_out.hit;
        end
    end

    // dot(d, n) products
    logic signed [63:0] r15_dn [3];
    t_vec3              r15_n, r15_p;
    logic [31:0]        r15_t;
    logic               r15_hit;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r15_dn[i] <= $signed(r14_d[i]) * $signed(r14_n[i]);
            end
            r15_n   <= r14_n;
            r15_p   <= r14_p;
            r15_t   <= r14_t;
            r15_hit <= r14_hit;
        end
    end

    // ------------------------------------------------------------------
    // output register: face test, normal flip, no-hit forces zeros
    // ------------------------------------------------------------------
    logic signed [65:0] dot;
    logic               front;
    t_vec3              nflip;
    logic               r_out_hit, r_out_front;
    logic [31:0]        r_out_t;
    t_vec3              r_out_p, r_out_n;

    assign dot   = 66'(r15_dn[0]) + 66'(r15_dn[1]) + 66'(r15_dn[2]);
    assign front = dot[65];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (front) begin
                nflip[i] = r15_n[i];
            end else if (r15_n[i] == 32'h8000_0000) begin
                nflip[i] = 32'h7fff_ffff;
            end else begin
                nflip[i] = -r15_n[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_hit   <= r15_hit;
            r_out_front <= r15_hit && front;
            r_out_t     <= r15_hit ? r15_t : '0;
            r_out_p     <= r15_hit ? r15_p : '0;
            r_out_n     <= r15_hit ? nflip : '0;
        end
    end

    assign o_hit.valid      = r_vld[NSTG-1];
    assign o_hit.hit_found  = r_out_hit;
    assign o_hit.hit_t      = r_out_t;
    assign o_hit.point_x    = r_out_p[0];
    assign o_hit.point_y    = r_out_p[1];
    assign o_hit.point_z    = r_out_p[2];
    assign o_hit.normal_x   = r_out_n[0];
    assign o_hit.normal_y   = r_out_n[1];
    assign o_hit.normal_z   = r_out_n[2];
    assign o_hit.front_face = r_out_front;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a held result freezes the whole pipe, input included
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit.valid && !o_hit.ready |-> !i_ray.ready)
        else $error("input taken while output stalled");

    // a miss carries no distance, point or face
    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit.valid && !o_hit.hit_found |->
            o_hit.hit_t == '0 && o_hit.point_x == '0 && o_hit.front_face == 1'b0)
        else $error("miss result not cleared");

    // reset empties the pipe
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_hit.valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

### bench/tb_ray_sphere_intersect_top.sv
`timescale 1ns / 1ps

module tb_ray_sphere_intersect_top;
    import ris_pkg::*;

    // Q16.16 one, and the saturation bounds
    localparam longint FIX_ONE = 65536;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    // index past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd12;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD = 700;
    localparam int LONG_HOLD_AT = 400;

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic signed [31:0] t_lo;
        logic signed [31:0] t_hi;
    } ray_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] t;
        logic signed [31:0] pt [3];
        logic signed [31:0] nrm [3];
        logic               front;
    } hit_t;

    logic i_clk;
    logic i_rst_n;

    ris_cfg_if cfg_bus ();
    ris_ray_if ray_bus ();
    ris_hit_if hit_bus ();

    ray_sphere_intersect_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_ray   (ray_bus),
        .o_hit   (hit_bus)
    );

    // sphere registers as the bench believes them to be
    longint sph_cen [3];
    longint sph_rad;

    ray_t pending_rays [$];
    hit_t expected_hits [$];
    int   fail_count;
    int   cycle_count;

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [31:0] clamp32(input longint v);
        if (v > S32_MAX) begin
            return 32'h7fff_ffff;
        end else if (v < S32_MIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // bit exact intersection of one ray with the current sphere
    function automatic hit_t trace_ray(input ray_t r);
        hit_t res;
        logic signed [191:0] a, hb, c, disc, s, trial, root, lo, hi, dot, w_d, w_oc, w_n;
        longint o [3], d [3], p [3], n [3];
        longint t, diff, mag, q;
        logic front;
        res.hit = 1'b0;
        res.t = '0;
        res.front = 1'b0;
        for (int i = 0; i < 3; i++) begin
            res.pt[i] = '0;
            res.nrm[i] = '0;
            o[i] = r.org[i];
            d[i] = r.dir[i];
        end
        if ((d[0] == 0 && d[1] == 0 && d[2] == 0) || sph_rad == 0) begin
            return res;
        end
        a = '0;
        hb = '0;
        c = sph_rad;
        c = -(c * c);
        for (int i = 0; i < 3; i++) begin
            w_d = d[i];
            w_oc = o[i] - sph_cen[i];
            a = a + w_d * w_d;
            hb = hb + w_oc * w_d;
            c = c + w_oc * w_oc;
        end
        disc = hb * hb - a * c;
        if (disc < 0) begin
            return res;
        end
        // floor square root, one bit at a time
        s = '0;
        for (int k = 67; k >= 0; k--) begin
            trial = s | (192'sd1 <<< k);
            if (trial * trial <= disc) begin
                s = trial;
            end
        end
        lo = r.t_lo;
        hi = r.t_hi;
        // near root first, then far root
        root = ((-hb - s) <<< FRAC_BITS) / a;
        if (root < lo || root > hi) begin
            root = ((-hb + s) <<< FRAC_BITS) / a;
            if (root < lo || root > hi) begin
                return res;
            end
        end
        t = root[63:0];
        dot = '0;
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(clamp32(o[i] + ((t * d[i]) >>> FRAC_BITS)));
            diff = p[i] - sph_cen[i];
            mag = (diff < 0) ? -diff : diff;
            q = (mag <<< FRAC_BITS) / sph_rad;
            n[i] = $signed(clamp32((diff < 0) ? -q : q));
            w_d = d[i];
            w_n = n[i];
            dot = dot + w_d * w_n;
        end
        front = (dot < 0);
        res.hit = 1'b1;
        res.t = t[31:0];
        res.front = front;
        for (int i = 0; i < 3; i++) begin
            res.pt[i] = p[i][31:0];
            res.nrm[i] = front ? n[i][31:0] : clamp32(-n[i]);
        end
        return res;
    endfunction

    // sender: one ray per transfer, random gap before each one outside bursts
    ray_t ray_on_bus;
    int   send_gap;
    logic send_burst;
    int   sent_count;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ray_bus.valid     <= 1'b0;
            ray_bus.origin_x  <= '0;
            ray_bus.origin_y  <= '0;
            ray_bus.origin_z  <= '0;
            ray_bus.dir_x     <= '0;
            ray_bus.dir_y     <= '0;
            ray_bus.dir_z     <= '0;
            ray_bus.range_min <= '0;
            ray_bus.range_max <= '0;
            send_gap   <= 0;
            send_burst <= 1'b0;
            sent_count <= 0;
        end else begin
            // prediction uses the ray that just transferred
            if (ray_bus.valid && ray_bus.ready) begin
                expected_hits.push_back(trace_ray(ray_on_bus));
                sent_count <= sent_count + 1;
                if (sent_count % 64 == 63) begin
                    send_burst <= ($urandom_range(0, 3) == 0);
                end
            end
            if (!ray_bus.valid || ray_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    ray_bus.valid <= 1'b0;
                end else if (pending_rays.size() > 0) begin
                    ray_on_bus = pending_rays.pop_front();
                    ray_bus.valid     <= 1'b1;
                    ray_bus.origin_x  <= ray_on_bus.org[0];
                    ray_bus.origin_y  <= ray_on_bus.org[1];
                    ray_bus.origin_z  <= ray_on_bus.org[2];
                    ray_bus.dir_x     <= ray_on_bus.dir[0];
                    ray_bus.dir_y     <= ray_on_bus.dir[1];
                    ray_bus.dir_z     <= ray_on_bus.dir[2];
                    ray_bus.range_min <= ray_on_bus.t_lo;
                    ray_bus.range_max <= ray_on_bus.t_hi;
                    send_gap <= send_burst ? 0 : $urandom_range(0, 16);
                end else begin
                    ray_bus.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, what, exp_v, act_v);
            fail_count++;
        end
    endtask

    // receiver: random stall after each result unless in a burst, plus one long
    // hold-off that lets the pipeline fill and push back on the ray input
    int   recv_stall;
    int   recv_count;
    logic recv_burst;

    always @(posedge i_clk) begin
        hit_t want;
        if (!i_rst_n) begin
            hit_bus.ready <= 1'b0;
            recv_stall <= 0;
            recv_count <= 0;
            recv_burst <= 1'b0;
        end else begin
            if (hit_bus.valid && hit_bus.ready) begin
                recv_count <= recv_count + 1;
                if (expected_hits.size() == 0) begin
                    $display("%0t unexpected result, expected none actual t %0d", $time,
                             hit_bus.hit_t);
                    fail_count++;
                end else begin
                    want = expected_hits.pop_front();
                    check_field("hit_found", want.hit, hit_bus.hit_found);
                    check_field("hit_t", want.t, hit_bus.hit_t);
                    check_field("point_x", want.pt[0], hit_bus.point_x);
                    check_field("point_y", want.pt[1], hit_bus.point_y);
                    check_field("point_z", want.pt[2], hit_bus.point_z);
                    check_field("normal_x", want.nrm[0], hit_bus.normal_x);
                    check_field("normal_y", want.nrm[1], hit_bus.normal_y);
                    check_field("normal_z", want.nrm[2], hit_bus.normal_z);
                    check_field("front_face", want.front, hit_bus.front_face);
                end
                if (recv_count % 50 == 49) begin
                    recv_burst <= ($urandom_range(0, 3) == 0);
                end
                if (recv_count == LONG_HOLD_AT) begin
                    recv_stall <= LONG_HOLD;
                    hit_bus.ready <= 1'b0;
                end else if (!recv_burst) begin
                    recv_stall <= $urandom_range(0, 16);
                    hit_bus.ready <= 1'b0;
                end
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                hit_bus.ready <= 1'b0;
            end else begin
                hit_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one register write through the config channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) begin
            @(posedge i_clk);
        end
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_CENTER_X: sph_cen[0] = $signed(val);
            REG_CENTER_Y: sph_cen[1] = $signed(val);
            REG_CENTER_Z: sph_cen[2] = $signed(val);
            REG_RADIUS:   sph_rad = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(input longint cx, input longint cy, input longint cz,
                              input longint rad);
        write_reg(REG_CENTER_X, cx[31:0]);
        write_reg(REG_CENTER_Y, cy[31:0]);
        write_reg(REG_CENTER_Z, cz[31:0]);
        write_reg(REG_RADIUS, {1'b0, rad[30:0]});
    endtask

    // waits until every queued ray has been sent and every result has come back
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_rays.size() != 0 || ray_bus.valid || expected_hits.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic add_ray(input longint ox, input longint oy, input longint oz,
                           input longint dx, input longint dy, input longint dz,
                           input longint lo, input longint hi);
        ray_t r;
        r.org[0] = ox[31:0];
        r.org[1] = oy[31:0];
        r.org[2] = oz[31:0];
        r.dir[0] = dx[31:0];
        r.dir[1] = dy[31:0];
        r.dir[2] = dz[31:0];
        r.t_lo = lo[31:0];
        r.t_hi = hi[31:0];
        pending_rays.push_back(r);
    endtask

    // mostly rays aimed near the sphere, some pure noise
    task automatic add_random_rays(input int count);
        ray_t r;
        longint off, aim;
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 9);
            for (int i = 0; i < 3; i++) begin
                if (sel < 2) begin
                    r.org[i] = $urandom;
                    r.dir[i] = $urandom;
                end else begin
                    off = longint'($signed($urandom)) >>> $urandom_range(6, 26);
                    r.org[i] = clamp32(sph_cen[i] + off);
                    aim = (-off) >>> $urandom_range(0, 6);
                    aim = aim + (longint'($signed($urandom)) >>> $urandom_range(10, 30));
                    r.dir[i] = (sel == 2 && $urandom_range(0, 3) == 0) ? 32'sd0 : clamp32(aim);
                end
            end
            case ($urandom_range(0, 3))
                0: r.t_lo = '0;
                1: r.t_lo = 32'h8000_0000;
                2: r.t_lo = $signed($urandom) >>> $urandom_range(8, 24);
                default: r.t_lo = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0, 1: r.t_hi = 32'h7fff_ffff;
                2: r.t_hi = $urandom_range(0, 32'h7fff_ffff) >> $urandom_range(0, 20);
                default: r.t_hi = $urandom;
            endcase
            pending_rays.push_back(r);
        end
    endtask

    initial begin
        longint cx, cy, cz;
        fail_count = 0;
        cycle_count = 0;
        sph_cen[0] = 0;
        sph_cen[1] = 0;
        sph_cen[2] = 0;
        sph_rad = FIX_ONE;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data  = '0;
        ray_bus.valid = 1'b0;
        hit_bus.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rays against the reset sphere: unit radius at the origin
        add_ray(0, 0, -5 * FIX_ONE, 0, 0, FIX_ONE, 0, S32_MAX);         // plain front hit
        add_ray(0, 0, -5 * FIX_ONE, 0, 0, 0, 0, S32_MAX);               // zero direction
        add_ray(0, 0, -5 * FIX_ONE, 0, 0, FIX_ONE, 10 * FIX_ONE, 0);    // empty interval
        add_ray(0, 5 * FIX_ONE, -5 * FIX_ONE, 0, 0, FIX_ONE, 0, S32_MAX); // miss
        add_ray(FIX_ONE, -5 * FIX_ONE, 0, 0, FIX_ONE, 0, 0, S32_MAX);   // tangent
        add_ray(0, 0, 0, FIX_ONE, 0, 0, 0, S32_MAX);                    // from inside
        add_ray(0, 0, -5 * FIX_ONE, 0, 0, FIX_ONE, 4 * FIX_ONE + FIX_ONE / 2, S32_MAX); // far
        add_ray(0, 0, -5 * FIX_ONE, 0, 0, FIX_ONE, 0, 3 * FIX_ONE);     // both roots out
        add_ray(0, 0, -5 * FIX_ONE, 0, 0, FIX_ONE, 4 * FIX_ONE, 4 * FIX_ONE); // point interval
        add_ray(0, 0, -5 * FIX_ONE, 0, 0, FIX_ONE, 6 * FIX_ONE, 6 * FIX_ONE); // far on edge
        add_ray(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MAX);
        add_ray(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MAX);
        add_ray(0, 0, -5 * FIX_ONE, 0, 0, 7 * FIX_ONE / 2, 0, S32_MAX); // non unit direction
        add_ray(0, 0, 5 * FIX_ONE, 0, 0, FIX_ONE, S32_MIN, S32_MAX);    // negative t
        add_ray(0, 0, 5 * FIX_ONE, 0, 0, FIX_ONE, 0, S32_MAX);          // sphere behind
        add_ray(FIX_ONE / 2, FIX_ONE / 3, -3 * FIX_ONE, -1, 1, FIX_ONE, 0, S32_MAX);
        add_ray(0, 0, -5 * FIX_ONE, 0, 0, -FIX_ONE, S32_MIN, S32_MAX);
        add_ray(0, 0, -5 * FIX_ONE, 1, 0, 0, S32_MIN, S32_MAX);         // tiny direction
        add_ray(0, 0, S32_MIN, 0, 0, S32_MAX, S32_MIN, S32_MAX);
        add_ray(S32_MAX, 0, 0, S32_MIN, 0, 0, 0, S32_MAX);
        wait_idle();

        // unit sphere written back explicitly, plus a dropped write
        write_reg(REG_UNUSED, $urandom);
        set_sphere(0, 0, 0, FIX_ONE);
        add_random_rays(200);
        wait_idle();

        // small random sphere, big phase that also takes the long hold-off
        cx = longint'($signed($urandom)) >>> 12;
        cy = longint'($signed($urandom)) >>> 12;
        cz = longint'($signed($urandom)) >>> 12;
        set_sphere(cx, cy, cz, $urandom_range(FIX_ONE / 4, 8 * FIX_ONE));
        add_random_rays(400);
        wait_idle();

        // zero radius never hits
        set_sphere(0, 0, 0, 0);
        add_random_rays(40);
        wait_idle();

        // smallest radius, normals saturate
        set_sphere(cx, cy, cz, 1);
        add_random_rays(100);
        wait_idle();

        // largest radius
        set_sphere(0, 0, 0, 64'h7fff_ffff);
        add_random_rays(100);
        wait_idle();

        // center at the positive corner
        set_sphere(S32_MAX, S32_MAX, S32_MAX, $urandom_range(1, 32'h7fff_ffff) >> 8);
        add_random_rays(100);
        wait_idle();

        // center at the negative corner
        set_sphere(S32_MIN, S32_MIN, S32_MIN, $urandom_range(1, 32'h7fff_ffff) >> 4);
        add_random_rays(100);
        wait_idle();

        // fully random registers
        set_sphere(longint'($signed($urandom)), longint'($signed($urandom)),
                   longint'($signed($urandom)), $urandom_range(0, 32'h7fff_ffff));
        add_random_rays(150);
        wait_idle();

        set_sphere(longint'($signed($urandom)) >>> 8, longint'($signed($urandom)) >>> 8,
                   longint'($signed($urandom)) >>> 8, 2 * FIX_ONE);
        add_random_rays(150);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/ris_pkg.sv
sv/ris_if.sv
sv/ray_sphere_intersect_top.sv
bench/tb_ray_sphere_intersect_top.sv
